// File: hw/rtl/sert_pkg.sv
package sert_pkg;

   // field widths
   localparam int STICK_W     = 12;
   localparam int TRIM_W      = 8;
   localparam int SHAPED_W    = 12;
   localparam int TRIM_AMT_W  = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // pipeline depth, input register through output register
   localparam int STAGES = 12;

   // divide by 100 as multiply by reciprocal: exact for inputs below 2**DIV_IN_W
   localparam int DIV_IN_W   = 20;
   localparam int DIV_MUL_W  = 21;
   localparam int DIV_PROD_W = DIV_IN_W + DIV_MUL_W;
   localparam int DIV_OUT_W  = 14;
   localparam int DIV_SHIFT  = 27;
   localparam logic [DIV_MUL_W-1:0] DIV100_MUL = 21'd1342178;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EXPO_POS = 3'd0,
      CSR_EXPO_NEG = 3'd1,
      CSR_RATE_POS = 3'd2,
      CSR_RATE_NEG = 3'd3,
      CSR_THR_EXPO = 3'd4,
      CSR_THR_TRIM = 3'd5
   } csr_index_type;

endpackage

// File: hw/rtl/sert_if.sv
interface sert_req_if import sert_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [STICK_W-1:0] stick_sample;
   logic signed [TRIM_W-1:0]  trim_value;

   modport source (output valid, stick_sample, trim_value, input ready);
   modport sink   (input valid, stick_sample, trim_value, output ready);
endinterface

interface sert_rsp_if import sert_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [SHAPED_W-1:0]   shaped_value;
   logic signed [TRIM_AMT_W-1:0] trim_amount;

   modport source (output valid, shaped_value, trim_amount, input ready);
   modport sink   (input valid, shaped_value, trim_amount, output ready);
endinterface

// File: hw/rtl/stick_expo_rate_trim_core.sv
// Stick expo, dual rate and trim shaping for one stick on a -1024..1024 scale. One word is
// taken per clock unless the request side is held; each of the 12 pipeline stages holds its
// own valid bit, so a stall on the result side fills empty stages first and only then holds
// the request side. Configuration registers are read live by the pipeline, so write them
// only while no word is in flight. Register map: 0 expo positive side, 1 expo negative side,
// 2 rate positive side, 3 rate negative side, 4 throttle expo enable, 5 throttle trim.
module stick_expo_rate_trim_core import sert_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   sert_req_if.sink               req_chan,
   sert_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef struct packed {
      logic               kneg;
      logic               kzero;
      logic               neg;
      logic signed [11:0] x;
      logic signed [7:0]  w;
      logic signed [7:0]  trim;
   } side_type;

   // configuration
   logic signed [7:0] expo_pos_ff, expo_neg_ff, rate_pos_ff, rate_neg_ff;
   logic              thr_expo_ff, thr_trim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expo_pos_ff <= '0;
         expo_neg_ff <= '0;
         rate_pos_ff <= '0;
         rate_neg_ff <= '0;
         thr_expo_ff <= 1'b0;
         thr_trim_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_EXPO_POS: expo_pos_ff <= csr_data;
            CSR_EXPO_NEG: expo_neg_ff <= csr_data;
            CSR_RATE_POS: rate_pos_ff <= csr_data;
            CSR_RATE_NEG: rate_neg_ff <= csr_data;
            CSR_THR_EXPO: thr_expo_ff <= csr_data[0];
            CSR_THR_TRIM: thr_trim_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // flow control: a stage advances when it is empty or the next one advances
   logic [STAGES-1:0] valid_ff, valid_in, adv;

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || rsp_chan.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? req_chan.valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = adv[0];

   // stage 0: capture
   logic signed [STICK_W-1:0] r0_sample_ff;
   logic signed [TRIM_W-1:0]  r0_trim_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         r0_sample_ff <= req_chan.stick_sample;
         r0_trim_ff   <= req_chan.trim_value;
      end
   end

   // stage 1: clamp, side select, fold the magnitude for a mirrored curve
   logic signed [11:0] s_clamp;
   logic signed [12:0] thr_sum;
   logic signed [11:0] x_sel, x_negd;
   logic               pos_side;
   logic signed [7:0]  k_raw, k_clamp, k_negd;
   logic [6:0]         k_mag;
   logic [10:0]        x_abs, ap_in;
   side_type           side_in;

   always_comb begin
      if (r0_sample_ff > 12'sd1024) begin
         s_clamp = 12'sd1024;
      end else if (r0_sample_ff < -12'sd1024) begin
         s_clamp = -12'sd1024;
      end else begin
         s_clamp = r0_sample_ff;
      end
      thr_sum  = {s_clamp[11], s_clamp} + 13'sd1024;
      x_sel    = thr_expo_ff ? $signed(thr_sum[12:1]) : s_clamp;
      pos_side = thr_expo_ff || (s_clamp > 12'sd0);
      k_raw    = pos_side ? expo_pos_ff : expo_neg_ff;
      if (k_raw > 8'sd100) begin
         k_clamp = 8'sd100;
      end else if (k_raw < -8'sd100) begin
         k_clamp = -8'sd100;
      end else begin
         k_clamp = k_raw;
      end
      k_negd = -k_clamp;
      k_mag  = k_clamp[7] ? k_negd[6:0] : k_clamp[6:0];
      x_negd = -x_sel;
      x_abs  = x_sel[11] ? x_negd[10:0] : x_sel[10:0];
      ap_in  = k_clamp[7] ? (11'd1024 - x_abs) : x_abs;

      side_in.kneg  = k_clamp[7];
      side_in.kzero = (k_clamp == 8'sd0);
      side_in.neg   = x_sel[11];
      side_in.x     = x_sel;
      side_in.w     = pos_side ? rate_pos_ff : rate_neg_ff;
      side_in.trim  = r0_trim_ff;
   end

   side_type    side_ff [1:9];
   logic [10:0] r1_ap_ff, r2_ap_ff;
   logic [6:0]  r1_kk_ff, r2_kk_ff, r3_kk_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         side_ff[1] <= side_in;
         r1_ap_ff   <= ap_in;
         r1_kk_ff   <= k_mag;
      end
      for (int i = 2; i <= 9; i++) begin
         if (adv[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // stage 2: square and linear term
   logic [21:0] sq_prod;
   logic [17:0] lin_prod;
   logic [20:0] r2_sq_ff;
   logic [16:0] r2_lin_ff, r3_lin_ff;

   assign sq_prod  = {11'b0, r1_ap_ff} * {11'b0, r1_ap_ff};
   assign lin_prod = {11'b0, 7'd100 - r1_kk_ff} * {7'b0, r1_ap_ff};

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         r2_sq_ff  <= sq_prod[20:0];
         r2_lin_ff <= lin_prod[16:0];
         r2_ap_ff  <= r1_ap_ff;
         r2_kk_ff  <= r1_kk_ff;
      end
   end

   // stage 3: cube, scaled down by 65536
   logic [31:0] cube_prod;
   logic [14:0] r3_cq_ff;

   assign cube_prod = {11'b0, r2_sq_ff} * {21'b0, r2_ap_ff};

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         r3_cq_ff  <= cube_prod[30:16];
         r3_lin_ff <= r2_lin_ff;
         r3_kk_ff  <= r2_kk_ff;
      end
   end

   // stage 4: weight the cube, add linear term and rounding
   logic [21:0] cqk_prod;
   logic [17:0] t_in;
   logic [17:0] r4_t_ff;

   assign cqk_prod = {7'b0, r3_cq_ff} * {15'b0, r3_kk_ff};
   assign t_in     = {1'b0, cqk_prod[20:4]} + {1'b0, r3_lin_ff} + 18'd50;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         r4_t_ff <= t_in;
      end
   end

   // stage 5: curve value = t / 100
   logic [DIV_OUT_W-1:0] curve_q;

   sert_div100 u_curve_div (
      .clock    (clock),
      .advance  (adv[5]),
      .dividend ({2'b0, r4_t_ff}),
      .quotient (curve_q)
   );

   // stage 6: unfold the curve, restore sign, throttle doubling, rate factor
   logic [10:0]        curve_m;
   logic signed [11:0] y12;
   logic signed [12:0] y_in, r6_y_ff;
   logic signed [8:0]  wp_in, r6_wp_ff;

   always_comb begin
      curve_m = side_ff[5].kneg ? (11'd1024 - curve_q[10:0]) : curve_q[10:0];
      if (side_ff[5].kzero) begin
         y12 = side_ff[5].x;
      end else if (side_ff[5].neg) begin
         y12 = -$signed({1'b0, curve_m});
      end else begin
         y12 = $signed({1'b0, curve_m});
      end
      y_in  = thr_expo_ff ? {y12, 1'b0} : {y12[11], y12};
      wp_in = {side_ff[5].w[7], side_ff[5].w} + 9'sd100;
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         r6_y_ff  <= y_in;
         r6_wp_ff <= wp_in;
      end
   end

   // stage 7: apply rate weight
   logic signed [21:0] rate_prod, r7_prod_ff;

   assign rate_prod = r6_y_ff * r6_wp_ff;

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         r7_prod_ff <= rate_prod;
      end
   end

   // stage 8: divide the magnitude by 100, truncating toward zero
   logic signed [21:0]   prod_negd;
   logic [19:0]          prod_mag;
   logic [DIV_OUT_W-1:0] rate_q;
   logic                 r8_sign_ff;

   assign prod_negd = -r7_prod_ff;
   assign prod_mag  = r7_prod_ff[21] ? prod_negd[19:0] : r7_prod_ff[19:0];

   sert_div100 u_rate_div (
      .clock    (clock),
      .advance  (adv[8]),
      .dividend (prod_mag),
      .quotient (rate_q)
   );

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         r8_sign_ff <= r7_prod_ff[21];
      end
   end

   // stage 9: signed shaped value before saturation
   logic signed [14:0] q_signed, v_in, r9_v_ff;

   always_comb begin
      q_signed = r8_sign_ff ? -$signed({1'b0, rate_q}) : $signed({1'b0, rate_q});
      v_in     = thr_expo_ff ? (q_signed - 15'sd1024) : q_signed;
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         r9_v_ff <= v_in;
      end
   end

   // stage 10: throttle trim product, saturate the shaped value
   logic signed [15:0]         span;
   logic signed [9:0]          trim_ofs;
   logic signed [23:0]         tp_in, r10_tp_ff;
   logic signed [SHAPED_W-1:0] shaped_in, r10_shaped_ff;
   logic signed [7:0]          r10_trim_ff;

   always_comb begin
      span     = 16'sd1024 - {r9_v_ff[14], r9_v_ff};
      trim_ofs = {{2{side_ff[9].trim[7]}}, side_ff[9].trim} + 10'sd125;
      tp_in    = span * trim_ofs;
      if (r9_v_ff > 15'sd1024) begin
         shaped_in = 12'sd1024;
      end else if (r9_v_ff < -15'sd1024) begin
         shaped_in = -12'sd1024;
      end else begin
         shaped_in = r9_v_ff[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[10]) begin
         r10_tp_ff     <= tp_in;
         r10_shaped_ff <= shaped_in;
         r10_trim_ff   <= side_ff[9].trim;
      end
   end

   // stage 11: trim amount, output register
   logic signed [23:0]           tp_adj, tq, tr_full;
   logic signed [TRIM_AMT_W-1:0] trim_amt_in, r11_trim_ff;
   logic signed [SHAPED_W-1:0]   r11_shaped_ff;

   always_comb begin
      // round toward zero before the shift
      tp_adj = r10_tp_ff + (r10_tp_ff[23] ? 24'sd2047 : 24'sd0);
      tq     = tp_adj >>> 11;
      if (thr_trim_ff) begin
         tr_full = tq <<< 1;
      end else begin
         tr_full = {{15{r10_trim_ff[7]}}, r10_trim_ff, 1'b0};
      end
      if (tr_full > 24'sd500) begin
         trim_amt_in = 10'sd500;
      end else if (tr_full < -24'sd500) begin
         trim_amt_in = -10'sd500;
      end else begin
         trim_amt_in = tr_full[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[11]) begin
         r11_shaped_ff <= r10_shaped_ff;
         r11_trim_ff   <= trim_amt_in;
      end
   end

   assign rsp_chan.valid        = valid_ff[STAGES-1];
   assign rsp_chan.shaped_value = r11_shaped_ff;
   assign rsp_chan.trim_amount  = r11_trim_ff;

endmodule

// File: hw/rtl/sert_div100.sv
module sert_div100 import sert_pkg::*; (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [DIV_IN_W-1:0]  dividend,
   output logic [DIV_OUT_W-1:0] quotient
);

   logic [DIV_PROD_W-1:0] prod;
   logic [DIV_OUT_W-1:0]  quotient_ff;
   logic [DIV_OUT_W-1:0]  quotient_in;

   assign prod        = {{DIV_MUL_W{1'b0}}, dividend} * {{DIV_IN_W{1'b0}}, DIV100_MUL};
   assign quotient_in = prod[DIV_SHIFT +: DIV_OUT_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

// File: test/sert_shape_checker.sv
`timescale 1ns / 1ps

module sert_shape_checker import sert_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   sert_req_if                    req_mon,
   sert_rsp_if                    rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     words_in_flight,
   output int                     results_checked,
   output int                     mismatch_count
);

   typedef struct packed {
      logic signed [STICK_W-1:0]    stick;
      logic signed [TRIM_W-1:0]     trim;
      logic signed [SHAPED_W-1:0]   shaped;
      logic signed [TRIM_AMT_W-1:0] trim_amt;
   } shaped_word_type;

   shaped_word_type shaped_fifo[$];

   int in_flight = 0;
   int checked_tally = 0;
   int fail_tally = 0;

   // shadow copy of the register file
   logic signed [7:0] expo_pos = '0;
   logic signed [7:0] expo_neg = '0;
   logic signed [7:0] rate_pos = '0;
   logic signed [7:0] rate_neg = '0;
   logic              thr_expo = 1'b0;
   logic              thr_trim = 1'b0;

   assign words_in_flight = in_flight;
   assign results_checked = checked_tally;
   assign mismatch_count  = fail_tally;

   function automatic int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // f(a,k) for a in 0..1024 and k in 0..100
   function automatic int expo_curve(int a, int k);
      longint t;
      t = longint'(a) * a * a / 65536 * k / 16;
      t += longint'(100 - k) * a + 50;
      return int'(t / 100);
   endfunction

   function automatic int apply_expo(int x, int k);
      int kc;
      int mag;
      int y;
      kc = clip(k, -100, 100);
      if (kc == 0)
         return x;
      mag = x < 0 ? -x : x;
      // mirror the curve for a negative amount
      if (kc < 0)
         y = 1024 - expo_curve(1024 - mag, -kc);
      else
         y = expo_curve(mag, kc);
      return x < 0 ? -y : y;
   endfunction

   function automatic shaped_word_type shape_stick(logic signed [STICK_W-1:0] stick,
                                                   logic signed [TRIM_W-1:0] trim);
      int s;
      int tr;
      int v;
      int w;
      int t;
      shaped_word_type res;
      s = clip(int'(stick), -1024, 1024);
      tr = int'(trim);
      if (thr_expo) begin
         v = 2 * apply_expo((s + 1024) / 2, int'(expo_pos));
         w = int'(rate_pos);
         v = v * (w + 100) / 100 - 1024;
      end else begin
         if (s > 0) begin
            v = apply_expo(s, int'(expo_pos));
            w = int'(rate_pos);
         end else begin
            v = apply_expo(s, int'(expo_neg));
            w = int'(rate_neg);
         end
         v = v * (w + 100) / 100;
      end
      // trim uses the value before saturation
      if (thr_trim)
         t = 2 * ((tr + 125) * (1024 - v) / 2048);
      else
         t = 2 * tr;
      res.stick    = stick;
      res.trim     = trim;
      res.shaped   = SHAPED_W'(clip(v, -1024, 1024));
      res.trim_amt = TRIM_AMT_W'(clip(t, -500, 500));
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      if (fail_tally < 200)
         $display("%0t ns: %s", $time, msg);
      fail_tally++;
   endtask

   always @(posedge clock) begin
      shaped_word_type want;
      if (reset) begin
         expo_pos <= '0;
         expo_neg <= '0;
         rate_pos <= '0;
         rate_neg <= '0;
         thr_expo <= 1'b0;
         thr_trim <= 1'b0;
         shaped_fifo.delete();
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_EXPO_POS: expo_pos <= csr_data;
               CSR_EXPO_NEG: expo_neg <= csr_data;
               CSR_RATE_POS: rate_pos <= csr_data;
               CSR_RATE_NEG: rate_neg <= csr_data;
               CSR_THR_EXPO: thr_expo <= csr_data[0];
               CSR_THR_TRIM: thr_trim <= csr_data[0];
               default: ;
            endcase
         end
         // pop before push so a word never matches its own prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (shaped_fifo.size() == 0) begin
               report_mismatch($sformatf("result word with nothing pending: shaped %0d trim %0d",
                                         rsp_mon.shaped_value, rsp_mon.trim_amount));
            end else begin
               want = shaped_fifo.pop_front();
               checked_tally++;
               if (rsp_mon.shaped_value !== want.shaped)
                  report_mismatch($sformatf("shaped_value got %0d want %0d (stick %0d trim %0d)",
                                            rsp_mon.shaped_value, want.shaped,
                                            want.stick, want.trim));
               if (rsp_mon.trim_amount !== want.trim_amt)
                  report_mismatch($sformatf("trim_amount got %0d want %0d (stick %0d trim %0d)",
                                            rsp_mon.trim_amount, want.trim_amt,
                                            want.stick, want.trim));
            end
         end
         if (req_mon.valid && req_mon.ready)
            shaped_fifo.push_back(shape_stick(req_mon.stick_sample, req_mon.trim_value));
      end
      in_flight = shaped_fifo.size();
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import sert_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_WORDS = 1050;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic                      src_valid = 1'b0;
   logic signed [STICK_W-1:0] src_stick = '0;
   logic signed [TRIM_W-1:0]  src_trim = '0;
   logic                      sink_ready = 1'b0;

   int words_in_flight;
   int results_checked;
   int mismatch_count;

   int words_sent = 0;
   int settings_used = 0;
   int burst_left = 0;
   int steady = 0;
   int quiet = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int stall_left = 0;

   sert_req_if req_chan();
   sert_rsp_if rsp_chan();

   assign req_chan.valid        = src_valid;
   assign req_chan.stick_sample = src_stick;
   assign req_chan.trim_value   = src_trim;
   assign rsp_chan.ready        = sink_ready;

   always #10 clock = ~clock;

   stick_expo_rate_trim_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   sert_shape_checker shape_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .words_in_flight (words_in_flight),
      .results_checked (results_checked),
      .mismatch_count  (mismatch_count)
   );

   // receiver: switch between stall styles every so often
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: sink_ready = 1'b1;
         1: sink_ready = 1'($urandom_range(0, 1));
         2: sink_ready = ($urandom_range(0, 7) != 0);
         default: begin
            // alternate runs of ready and stall
            if (stall_left == 0) begin
               sink_ready = ~sink_ready;
               stall_left = $urandom_range(1, 25);
            end else begin
               stall_left--;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if ((src_valid && req_chan.ready) || (rsp_chan.valid && sink_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic load_settings(int ep, int en, int rp, int rn, int te, int tt);
      csr_write(CSR_EXPO_POS, CSR_DATA_W'(ep));
      csr_write(CSR_EXPO_NEG, CSR_DATA_W'(en));
      csr_write(CSR_RATE_POS, CSR_DATA_W'(rp));
      csr_write(CSR_RATE_NEG, CSR_DATA_W'(rn));
      csr_write(CSR_THR_EXPO, CSR_DATA_W'(te));
      csr_write(CSR_THR_TRIM, CSR_DATA_W'(tt));
      settings_used++;
   endtask

   // hold off until every predicted word has come back
   task automatic drain_pipe();
      src_valid = 1'b0;
      burst_left = 0;
      while (words_in_flight != 0)
         @(negedge clock);
      repeat (STAGES + 4) @(negedge clock);
   endtask

   task automatic send_word(int stick, int trim);
      int gap;
      if (burst_left == 0) begin
         if (steady != 0)
            gap = 0;
         else if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(10, 40);
         else
            gap = $urandom_range(0, 4);
         if (gap > 0) begin
            src_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      src_stick = STICK_W'(stick);
      src_trim = TRIM_W'(trim);
      src_valid = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      burst_left--;
      words_sent++;
   endtask

   function automatic int rand_stick();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 6))
               0: return -1024;
               1: return 1024;
               2: return 0;
               3: return 1;
               4: return -1;
               5: return 1023;
               default: return -1023;
            endcase
         end
         1: return $urandom_range(0, 4095) - 2048;
         default: return $urandom_range(0, 2048) - 1024;
      endcase
   endfunction

   function automatic int rand_trim();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 255) - 128;
         1: return $urandom_range(0, 1) != 0 ? 125 : -125;
         default: return $urandom_range(0, 250) - 125;
      endcase
   endfunction

   function automatic int rand_expo();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 255) - 128;
         1: begin
            case ($urandom_range(0, 2))
               0: return 100;
               1: return -100;
               default: return 0;
            endcase
         end
         default: return $urandom_range(0, 200) - 100;
      endcase
   endfunction

   function automatic int rand_rate();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 255) - 128;
         1: return $urandom_range(0, 1) != 0 ? -100 : 0;
         default: return $urandom_range(0, 100) - 100;
      endcase
   endfunction

   initial begin
      int random_sent;
      int phase_len;
      int pause_at;
      int flags;
      random_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: extremes of both fields, stick beyond full scale
      send_word(-1024, -125);
      send_word(1024, 125);
      send_word(0, 0);
      send_word(1, -1);
      send_word(-1, 1);
      send_word(2047, 127);
      send_word(-2048, -128);

      // full expo on one side, mirrored full expo on the other
      drain_pipe();
      load_settings(100, -100, 0, -100, 0, 0);
      send_word(1024, 0);
      send_word(512, 0);
      send_word(-512, 0);
      send_word(-1024, 0);
      send_word(0, 0);

      // expo and rate beyond their ranges
      drain_pipe();
      load_settings(127, -128, 127, -128, 0, 0);
      send_word(700, 3);
      send_word(-700, -3);
      send_word(1024, 0);
      send_word(-1024, 0);

      // throttle expo with low-end trim
      drain_pipe();
      load_settings(-50, 0, -30, 0, 1, 1);
      send_word(-1024, -125);
      send_word(0, 125);
      send_word(1024, 127);
      send_word(-2048, -128);
      send_word(333, 0);

      while (random_sent < RANDOM_WORDS) begin
         drain_pipe();
         flags = $urandom_range(0, 3);
         load_settings(rand_expo(), rand_expo(), rand_rate(), rand_rate(),
                       ($urandom_range(0, 127) << 1) | (flags & 1),
                       ($urandom_range(0, 127) << 1) | (flags >> 1));
         steady = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(40, 160);
         pause_at = $urandom_range(0, 2) == 0 ? $urandom_range(1, phase_len - 1) : -1;
         for (int i = 0; i < phase_len && random_sent < RANDOM_WORDS; i++) begin
            if (i == pause_at)
               drain_pipe();
            send_word(rand_stick(), rand_trim());
            random_sent++;
         end
      end

      src_valid = 1'b0;
      while (words_in_flight != 0)
         @(negedge clock);
      repeat (STAGES + 8) @(posedge clock);
      $display("Sent %0d words under %0d register settings, incl. throttle modes,", words_sent,
               settings_used);
      $display("mirrored expo and out-of-range inputs; %0d results compared", results_checked);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/sert_pkg.sv
hw/rtl/sert_if.sv
hw/rtl/sert_div100.sv
hw/rtl/stick_expo_rate_trim_core.sv
test/sert_shape_checker.sv
test/testbench.sv
